FILE: hdl/assert_macros.svh
// assertion macros used by int128_alu_core
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define ASSERT_IMP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// plain invariant checked on every rising clock edge
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

FILE: hdl/i128alu_pkg.sv
// package for the 128-bit integer alu: opcodes and widths
// no dependencies
`default_nettype none
package i128alu_pkg;
  localparam int unsigned DefWordBits = 128;
  localparam int unsigned OpBits = 4;
  localparam int unsigned ShBits = 8;

  typedef enum logic [OpBits-1:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_AND = 4'd4, OP_OR = 4'd5, OP_XOR = 4'd6, OP_NOT = 4'd7,
    OP_SHL = 4'd8, OP_SHR = 4'd9, OP_ROL = 4'd10, OP_ROR = 4'd11
  } op_t;
endpackage
`default_nettype wire

FILE: hdl/i128alu_div_cell.sv
// one restoring-division step cell: one quotient bit per cycle per item while en is high
// depends on i128alu_pkg
`default_nettype none
module i128alu_div_cell
  import i128alu_pkg::*;
#(
  parameter int unsigned W = DefWordBits
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [W-1:0] rem_in,
  input  wire logic [W-1:0] num_in,
  input  wire logic [W-1:0] den_in,
  output logic      [W-1:0] rem_out,
  output logic      [W-1:0] num_out,
  output logic      [W-1:0] den_out
);
  logic [W:0] trial;
  logic [W:0] shifted;

  // numerator register shifts left, quotient bits fill from the bottom
  always_comb begin
    shifted = {rem_in, num_in[W-1]};
    trial = shifted - {1'b0, den_in};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!trial[W]) begin
        rem_out <= trial[W-1:0];
        num_out <= {num_in[W-2:0], 1'b1};
      end else begin
        rem_out <= shifted[W-1:0];
        num_out <= {num_in[W-2:0], 1'b0};
      end
      den_out <= den_in;
    end
  end
endmodule
`default_nettype wire

FILE: hdl/i128alu_mul.sv
// pipelined wrap-around multiplier from 32x32 partial products
// depends on i128alu_pkg
`default_nettype none
module i128alu_mul
  import i128alu_pkg::*;
#(
  parameter int unsigned W = DefWordBits
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  output logic      [W-1:0] p
);
  localparam int unsigned L = (W + 31) / 32;
  localparam int unsigned WP = L * 32;
  // one stage per 32-bit limb of a
  localparam int unsigned Stages = L;

  // stage 0 registers operands, stage s adds the partial products of limb s-1 of a
  logic [WP-1:0] acc [Stages];
  logic [WP-1:0] ra  [Stages];
  logic [WP-1:0] rb  [Stages];
  logic [WP-1:0] prod_row [L];

  always_comb begin
    for (int i = 0; i < L; i++) begin
      prod_row[i] = '0;
      for (int j = 0; j < L; j++) begin
        if (i + j < L) begin
          prod_row[i] = prod_row[i] +
            (WP'(64'(ra[i][i*32 +: 32]) * 64'(rb[i][j*32 +: 32])) << ((i + j) * 32));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc[0] <= '0;
      ra[0] <= WP'(a);
      rb[0] <= WP'(b);
      for (int s = 1; s < Stages; s++) begin
        acc[s] <= acc[s-1] + prod_row[s-1];
        ra[s] <= ra[s-1];
        rb[s] <= rb[s-1];
      end
    end
  end

  assign p = W'(acc[Stages-1] + prod_row[Stages-1]);
endmodule
`default_nettype wire

FILE: hdl/int128_alu_core.sv
// Fully pipelined 128-bit integer alu.
// One beat in on s_axis (op, operands, shift count), one beat out on m_axis
// (result and divide-by-zero flag), in the same order.
// An item enters every cycle unless the receiver stalls; the pipe holds
// WORD_BITS+2 stages: an entry stage, the chain of division cells, one
// quotient bit per cell, and the output register. All operations travel
// the same chain so results never reorder.
// Multiplication runs in a partial-product pipe, one stage per 32-bit limb
// (four at the default width), alongside the first cells.
// The whole pipe advances only when the output register is free or being
// taken: s_axis_tready = !m_axis_tvalid || m_axis_tready. When the receiver
// stalls, the pipe freezes and holds every item.
// Reset clears all valid flags; no item is lost or invented afterwards.
// s_axis_tdata: op[3:0], a_hi[67:4], a_lo[131:68], b_hi[195:132],
//   b_lo[259:196], shift_amount[267:260], zero pad to 272 bits.
// m_axis_tdata: result_hi[63:0], result_lo[127:64], divide_by_zero[128],
//   zero pad to 136 bits.
`default_nettype none
`include "assert_macros.svh"
module int128_alu_core
  import i128alu_pkg::*;
#(
  parameter int unsigned WORD_BITS = DefWordBits
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [271:0] s_axis_tdata,  // op, a_hi, a_lo, b_hi, b_lo, shift_amount
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic      [135:0] m_axis_tdata   // result_hi, result_lo, divide_by_zero
);
  localparam int unsigned W = WORD_BITS;
  localparam int unsigned D = W + 2; // cells plus entry stage plus output register
  localparam int unsigned MulLat = (W + 31) / 32;

  logic         adv;
  logic [W-1:0] a_in, b_in, a_n, b_n;
  logic         na, nb;
  logic [OpBits-1:0] op_in;
  logic [ShBits-1:0] sh_in;
  logic [W-1:0] quick;
  logic [W-1:0] mul_p;

  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  assign op_in = s_axis_tdata[3:0];
  assign a_in  = W'({s_axis_tdata[67:4], s_axis_tdata[131:68]});
  assign b_in  = W'({s_axis_tdata[195:132], s_axis_tdata[259:196]});
  assign sh_in = s_axis_tdata[267:260];
  assign na = a_in[W-1];
  assign nb = b_in[W-1];
  assign a_n = na ? (~a_in + W'(1)) : a_in;
  assign b_n = nb ? (~b_in + W'(1)) : b_in;

  // every operation other than multiply and divide, computed combinationally
  always_comb begin
    quick = '0;
    unique case (op_in)
      OP_ADD: quick = a_in + b_in;
      OP_SUB: quick = a_in - b_in;
      OP_AND: quick = a_in & b_in;
      OP_OR:  quick = a_in | b_in;
      OP_XOR: quick = a_in ^ b_in;
      OP_NOT: quick = ~a_in;
      OP_SHL: quick = (9'(sh_in) < 9'(W)) ? (a_in << sh_in) : '0;
      OP_SHR: quick = (9'(sh_in) < 9'(W)) ? (a_in >> sh_in) : '0;
      OP_ROL: quick = {a_in[W-2:0], a_in[W-1]};
      OP_ROR: quick = {a_in[0], a_in[W-1:1]};
      default: quick = '0;
    endcase
  end

  // sideband carried alongside the divider chain
  logic              vld   [D];
  logic [OpBits-1:0] opr   [D];
  logic [W-1:0]      qk    [D];
  logic              neg   [D];
  logic              dz    [D];
  logic [W-1:0]      mres  [D];
  logic [W-1:0]      rem   [W+1];
  logic [W-1:0]      num   [W+1];
  logic [W-1:0]      den   [W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < D; i++) vld[i] <= 1'b0;
    end else if (adv) begin
      vld[0] <= s_axis_tvalid;
      for (int i = 1; i < D; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      opr[0] <= op_in;
      qk[0] <= quick;
      neg[0] <= na ^ nb;
      dz[0] <= (op_in == OP_DIV) && (b_in == '0);
      mres[0] <= '0;
      rem[0] <= '0;
      num[0] <= a_n;
      den[0] <= b_n;
      for (int i = 1; i < D; i++) begin
        opr[i] <= opr[i-1];
        qk[i] <= qk[i-1];
        neg[i] <= neg[i-1];
        dz[i] <= dz[i-1];
        // product of the item in stage i-1 is ready at the multiplier output
        mres[i] <= (i == MulLat) ? mul_p : mres[i-1];
      end
    end
  end

  i128alu_mul #(.W(W)) u_mul (
    .clk(clk), .en(adv), .a(a_in), .b(b_in), .p(mul_p)
  );

  for (genvar g = 0; g < W; g++) begin : g_cell
    i128alu_div_cell #(.W(W)) u_cell (
      .clk(clk), .en(adv),
      .rem_in(rem[g]), .num_in(num[g]), .den_in(den[g]),
      .rem_out(rem[g+1]), .num_out(num[g+1]), .den_out(den[g+1])
    );
  end

  // sign fix and result selection: quotient num[W] aligns with stage W
  logic [W-1:0] sel;
  logic [W-1:0] quo;
  assign quo = neg[W] ? (~num[W] + W'(1)) : num[W];
  always_comb begin
    priority if (opr[W] == OP_MUL) sel = mres[W];
    else if (opr[W] == OP_DIV) sel = dz[W] ? '0 : quo;
    else sel = qk[W];
  end

  logic [W-1:0] res;
  logic         res_dz;
  always_ff @(posedge clk) begin
    if (adv) begin
      res <= sel;
      res_dz <= dz[W];
    end
  end

  assign m_axis_tvalid = vld[D-1];
  logic [127:0] res_x;
  assign res_x = 128'(res);
  assign m_axis_tdata = {7'b0, res_dz, res_x[63:0], res_x[127:64]};

  `ASSERT_IMP(a_stall_hold, clk, rst,
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata),
    "output beat changed under stall")
  `ASSERT_IMP(a_ready_rule, clk, rst,
    s_axis_tready == (!m_axis_tvalid || m_axis_tready),
    "input ready does not follow output stage")
  `ASSERT_IMP(a_dz_div, clk, rst,
    (vld[W] && dz[W]) |-> (opr[W] == OP_DIV),
    "divide flag on non-divide item")
  `ASSERT_IMP(a_rst_empty, clk, rst, $past(rst) |-> !m_axis_tvalid,
    "output valid right after reset")
endmodule
`default_nettype wire
